// ----- rtl/sau_pkg.sv -----
// Shared types and constants for the selectable activation unit.
// Holds the function select codes, Q30 constants, CORDIC angle table and
// the reciprocal table for the exp series. No dependencies.
`default_nettype none

package sau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  localparam logic [15:0] LEAK_SLOPE_RESET = 16'd655;

  typedef enum logic [2:0] {
    MODE_ATAN    = 3'd0,
    MODE_STEP    = 3'd1,
    MODE_ELU     = 3'd2,
    MODE_SIGMOID = 3'd3,
    MODE_SINE    = 3'd4,
    MODE_TANH    = 3'd5,
    MODE_LEAKY   = 3'd6,
    MODE_RELU    = 3'd7
  } mode_t;

  // Q30 constants
  localparam logic [63:0] Q30_ONE      = 64'd1073741824;
  localparam logic [63:0] Q30_PI       = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI  = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI   = 64'd6746518852;
  localparam logic [63:0] Q30_LN2      = 64'd744261118;
  localparam logic [63:0] Q30_GAIN_INV = 64'd652032874;
  // exp(-t) is zero from 40*ln2 on
  localparam logic [63:0] EXP_LIMIT    = 64'd29770444720;

  localparam int CORDIC_STEPS = 30;
  localparam int EXP_TERMS    = 13;

  localparam logic [31:0] ATAN_TBL [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  // floor(v/n) = (v * RECIP[n]) >> RSHIFT[n], exact for v < 2^31
  localparam logic [31:0] RECIP [EXP_TERMS+1] = '{
    32'd0, 32'd2147483648, 32'd2147483648, 32'd2863311531, 32'd2147483648,
    32'd3435973837, 32'd2863311531, 32'd2454267027, 32'd2147483648,
    32'd3817748708, 32'd3435973837, 32'd3123612579, 32'd2863311531,
    32'd2643056798
  };
  localparam logic [5:0] RSHIFT [EXP_TERMS+1] = '{
    6'd0, 6'd31, 6'd32, 6'd33, 6'd33, 6'd34, 6'd34, 6'd34, 6'd34,
    6'd35, 6'd35, 6'd35, 6'd35, 6'd35
  };

endpackage

`default_nettype wire

// ----- rtl/sau_stage.sv -----
// One register slice of the activation pipeline with valid/ready flow.
// Payload type comes in as a type parameter. No package dependency.
`default_nettype none

module sau_stage #(
  parameter type T = logic
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_valid,
  input  wire T     up_data,
  output logic      up_ready,
  output logic      dn_valid,
  output T          dn_data,
  input  wire logic dn_ready
);

  // slot is free when empty or when its item leaves this cycle
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= up_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/selectable_activation_unit.sv -----
// Throughput: one item per cycle while out_ready is high; every stage is
// a register slice, so a bubble anywhere lets a new item in even while the
// output item waits. Depth is set by the reduction stages, the 30 CORDIC
// iterations and the 31-bit divider.
// Reset (rst, synchronous): empties all stages, leak_slope back to 655.
// Depends on sau_pkg and sau_stage.
`default_nettype none

module selectable_activation_unit #(
  parameter int DATA_WIDTH = sau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = sau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input items
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] value,
  input  wire logic [2:0]                   mode,
  input  wire logic                         output_layer,
  // result items
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      activation,
  output logic                              mode_error,
  // leak_slope register
  input  wire logic                         cfg_we,
  input  wire logic [15:0]                  cfg_wdata
);

  localparam int DW   = DATA_WIDTH;
  localparam int SH   = 30 - FRAC_BITS;            // Q30 <-> data shift
  localparam int MAGW = DW + SH;                   // |x| in Q30
  // quotient bits of |x|/2pi
  localparam int QB   = (DW - FRAC_BITS - 3 > 1) ? DW - FRAC_BITS - 3 : 1;
  localparam int LA   = (QB > 6) ? QB : 6;         // reduction stages
  localparam int CA   = (FRAC_BITS + 28 > DW + 27) ? FRAC_BITS + 28 : DW + 27;
  localparam int CW   = CA + 4;                    // CORDIC x/y width
  localparam int ZW   = 33;                        // CORDIC angle width
  localparam int VW   = (DW + 2 > 34) ? DW + 2 : 34;
  localparam int NDIV = 16;                        // two quotient bits a stage

  // stage map
  localparam int F_ST = LA + 1;                    // sine fold, CORDIC init
  localparam int B0   = F_ST + 1;                  // CORDIC + exp series
  localparam int C0   = B0 + sau_pkg::CORDIC_STEPS;
  localparam int R1   = C0 + NDIV;                 // select and round
  localparam int R2   = R1 + 1;                    // saturate
  localparam int NST  = R2 + 1;

  typedef struct packed {
    sau_pkg::mode_t           mode;
    logic                     err;
    logic signed [DW-1:0]     x;
    logic                     clamp;    // exp argument at or past 40*ln2
    logic [34:0]              tr;       // exp argument, then remainder r
    logic [5:0]               k;
    logic [MAGW-1:0]          mr;       // |x| reduced mod 2pi
    logic                     vec;      // CORDIC vectoring (atan)
    logic signed [CW-1:0]     cx;
    logic signed [CW-1:0]     cy;
    logic signed [ZW-1:0]     z;
    logic [30:0]              term;
    logic [60:0]              prod;
    logic [31:0]              sum;
    logic [30:0]              e;
    logic signed [47:0]       eprod;
    logic signed [DW+16:0]    lprod;
    logic [31:0]              rem;
    logic [30:0]              numlo;
    logic [30:0]              quo;
    logic [31:0]              den;
    logic signed [VW-1:0]     val;
    logic signed [DW-1:0]     res;
  } item_t;

  logic [15:0] leak_slope;

  always_ff @(posedge clk) begin
    if (rst) begin
      leak_slope <= sau_pkg::LEAK_SLOPE_RESET;
    end else if (cfg_we) begin
      leak_slope <= cfg_wdata;
    end
  end

  // Q30 to data format, half up
  function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] a);
    logic signed [63:0] t;
    t = a + (64'sd1 <<< (SH - 1));
    return t >>> SH;
  endfunction

  // Entry stage: decode, |x| in Q30, exp argument and its range check.
  function automatic item_t prep_fn(input logic signed [DW-1:0] v,
                                    input logic [2:0] md,
                                    input logic outl);
    item_t q;
    logic signed [63:0] xs;
    logic [63:0] mag;
    logic [63:0] t;
    q = '0;
    q.mode = sau_pkg::mode_t'(md);
    q.x = v;
    q.err = outl && (md == sau_pkg::MODE_LEAKY || md == sau_pkg::MODE_RELU);
    xs = {{(64-DW){v[DW-1]}}, v};
    mag = (xs < 0) ? 64'(-xs) : 64'(xs);
    mag = mag << SH;
    t = (md == sau_pkg::MODE_TANH) ? (mag << 1) : mag;
    q.clamp = (t >= sau_pkg::EXP_LIMIT);
    q.tr = t[34:0];
    q.mr = mag[MAGW-1:0];
    return q;
  endfunction

  function automatic item_t step_fn(input int i, input item_t p,
                                    input logic [15:0] slope);
    item_t q;
    int j;
    int c;
    int n;
    int s;
    logic [2:0] b;
    logic [63:0] w;
    logic [63:0] lim;
    logic signed [63:0] m;
    logic signed [63:0] a;
    logic signed [63:0] xs;
    logic signed [63:0] hi;
    logic signed [CW-1:0] cx, cy, dx, dy;
    logic signed [ZW-1:0] z, tz;
    logic rot;
    logic [60:0] pr;
    logic [30:0] h31;
    logic [62:0] rp;
    logic [31:0] shs;
    logic signed [32:0] ed;
    logic signed [16:0] sl;
    logic signed [49:0] ep;
    logic signed [DW+16:0] lp;
    logic [60:0] num;
    logic [30:0] om;
    logic [32:0] rr;
    logic qb;
    q = p;
    xs = {{(64-DW){p.x[DW-1]}}, p.x};
    sl = $signed({1'b0, slope});
    if (i <= LA) begin
      // restoring division: k = t / ln2, r = t mod ln2; |x| mod 2pi
      j = i - 1;
      if (j < 6) begin
        b = 3'(5 - j);
        w = 64'(p.tr);
        lim = sau_pkg::Q30_LN2 << b;
        if (w >= lim) begin
          w = w - lim;
          q.tr = w[34:0];
          q.k[b] = 1'b1;
        end
      end
      if (j < QB) begin
        w = 64'(p.mr);
        lim = sau_pkg::Q30_TWO_PI << (QB - 1 - j);
        if (w >= lim) begin
          w = w - lim;
          q.mr = w[MAGW-1:0];
        end
      end
    end else if (i == F_ST) begin
      // sine: truncating remainder, wrap to (-pi, pi], fold to +-pi/2
      w = 64'(p.mr);
      m = p.x[DW-1] ? -$signed(w) : $signed(w);
      if (m > $signed(sau_pkg::Q30_PI)) begin
        m = m - $signed(sau_pkg::Q30_TWO_PI);
      end else if (m <= -$signed(sau_pkg::Q30_PI)) begin
        m = m + $signed(sau_pkg::Q30_TWO_PI);
      end
      if (m > $signed(sau_pkg::Q30_HALF_PI)) begin
        m = $signed(sau_pkg::Q30_PI) - m;
      end else if (m < -$signed(sau_pkg::Q30_HALF_PI)) begin
        m = -$signed(sau_pkg::Q30_PI) - m;
      end
      if (p.mode == sau_pkg::MODE_ATAN) begin
        q.vec = 1'b1;
        cx = '0;
        cx[FRAC_BITS+28] = 1'b1;
        cy = {{(CW-DW){p.x[DW-1]}}, p.x};
        q.cx = cx;
        q.cy = cy <<< 28;
        q.z = '0;
      end else begin
        q.vec = 1'b0;
        q.cx = sau_pkg::Q30_GAIN_INV[CW-1:0];
        q.cy = '0;
        q.z = m[ZW-1:0];
      end
      q.term = 31'h4000_0000;
      q.sum = 32'h4000_0000;
    end else if (i < C0) begin
      c = i - B0;
      // one CORDIC iteration
      cx = p.cx;
      cy = p.cy;
      z = p.z;
      dx = cx >>> c;
      dy = cy >>> c;
      tz = $signed({1'b0, sau_pkg::ATAN_TBL[c]});
      rot = p.vec ? (cy < 0) : (z >= 0);
      if (rot) begin
        q.cx = cx - dy;
        q.cy = cy + dx;
        q.z = z - tz;
      end else begin
        q.cx = cx + dy;
        q.cy = cy - dx;
        q.z = z + tz;
      end
      // exp(-r) series: term n multiplies at 2n-2, divides by n at 2n-1,
      // and is added at 2n
      if ((c & 1) == 0 && c <= 24) begin
        pr = p.term * p.tr[29:0];
        q.prod = pr;
      end
      if ((c & 1) == 1 && c <= 25) begin
        n = (c + 1) >> 1;
        h31 = p.prod[60:30];
        rp = h31 * sau_pkg::RECIP[n];
        rp = rp >> sau_pkg::RSHIFT[n];
        q.term = rp[30:0];
      end
      if ((c & 1) == 0 && c >= 2 && c <= 26) begin
        n = c >> 1;
        if ((n & 1) == 1) begin
          q.sum = p.sum - {1'b0, p.term};
        end else begin
          q.sum = p.sum + {1'b0, p.term};
        end
      end
      if (c == 27) begin
        shs = p.sum >> p.k;
        q.e = p.clamp ? '0 : shs[30:0];
      end
      if (c == 28) begin
        ed = $signed({2'b0, p.e}) - 33'sh0_4000_0000;
        ep = ed * sl;
        q.eprod = ep[47:0];
        lp = p.x * sl;
        q.lprod = lp;
        om = 31'h4000_0000 - p.e;
        if (p.mode == sau_pkg::MODE_SIGMOID) begin
          num = p.x[DW-1] ? {p.e, 30'b0} : (61'h1 << 60);
        end else begin
          num = {om, 30'b0};
        end
        q.rem = {2'b0, num[60:31]};
        q.numlo = num[30:0];
        q.quo = '0;
        q.den = {1'b0, p.e} + 32'h4000_0000;
      end
    end else if (i < R1) begin
      // restoring divider, two quotient bits per stage
      for (int u = 0; u < 2; u++) begin
        s = 2 * (i - C0) + u;
        if (s < 31) begin
          rr = {q.rem, q.numlo[30]};
          q.numlo = {q.numlo[29:0], 1'b0};
          qb = (rr >= {1'b0, q.den});
          if (qb) begin
            rr = rr - {1'b0, q.den};
          end
          q.rem = rr[31:0];
          q.quo = {q.quo[29:0], qb};
        end
      end
    end else if (i == R1) begin
      case (p.mode)
        sau_pkg::MODE_ATAN: begin
          a = rnd_q30({{(64-ZW){p.z[ZW-1]}}, p.z});
        end
        sau_pkg::MODE_STEP: begin
          a = p.x[DW-1] ? 64'sd0 : (64'sd1 <<< FRAC_BITS);
        end
        sau_pkg::MODE_ELU: begin
          a = {{16{p.eprod[47]}}, p.eprod} + (64'sd1 <<< (45 - FRAC_BITS));
          a = (xs > 0) ? xs : (a >>> (46 - FRAC_BITS));
        end
        sau_pkg::MODE_SIGMOID: begin
          a = rnd_q30($signed({33'b0, p.quo}));
        end
        sau_pkg::MODE_SINE: begin
          a = rnd_q30({{(64-CW){p.cy[CW-1]}}, p.cy});
        end
        sau_pkg::MODE_TANH: begin
          a = $signed({33'b0, p.quo});
          a = rnd_q30(p.x[DW-1] ? -a : a);
        end
        sau_pkg::MODE_LEAKY: begin
          a = {{(64-DW-17){p.lprod[DW+16]}}, p.lprod} + 64'sd32768;
          a = p.x[DW-1] ? (a >>> 16) : xs;
        end
        sau_pkg::MODE_RELU: begin
          a = (xs > 0) ? xs : 64'sd0;
        end
        default: begin
          a = 64'sd0;
        end
      endcase
      q.val = a[VW-1:0];
    end else begin
      a = {{(64-VW){p.val[VW-1]}}, p.val};
      hi = (64'sd1 <<< (DW - 1)) - 64'sd1;
      if (p.err) begin
        q.res = '0;
      end else if (a > hi) begin
        q.res = hi[DW-1:0];
      end else if (a < -hi - 64'sd1) begin
        w = 64'(-hi - 64'sd1);
        q.res = w[DW-1:0];
      end else begin
        q.res = a[DW-1:0];
      end
    end
    return q;
  endfunction

  item_t          st_in  [NST];
  item_t          st_out [NST];
  logic [NST-1:0] st_valid;
  logic [NST-1:0] st_ready;

  for (genvar g = 0; g < NST; g++) begin : g_pipe
    if (g == 0) begin : g_first
      assign st_in[g] = prep_fn(value, mode, output_layer);
      sau_stage #(.T(item_t)) u_stage (
        .clk      (clk),
        .rst      (rst),
        .up_valid (in_valid),
        .up_data  (st_in[g]),
        .up_ready (st_ready[g]),
        .dn_valid (st_valid[g]),
        .dn_data  (st_out[g]),
        .dn_ready (st_ready[g+1])
      );
    end else if (g == NST - 1) begin : g_last
      assign st_in[g] = step_fn(g, st_out[g-1], leak_slope);
      sau_stage #(.T(item_t)) u_stage (
        .clk      (clk),
        .rst      (rst),
        .up_valid (st_valid[g-1]),
        .up_data  (st_in[g]),
        .up_ready (st_ready[g]),
        .dn_valid (st_valid[g]),
        .dn_data  (st_out[g]),
        .dn_ready (out_ready)
      );
    end else begin : g_mid
      assign st_in[g] = step_fn(g, st_out[g-1], leak_slope);
      sau_stage #(.T(item_t)) u_stage (
        .clk      (clk),
        .rst      (rst),
        .up_valid (st_valid[g-1]),
        .up_data  (st_in[g]),
        .up_ready (st_ready[g]),
        .dn_valid (st_valid[g]),
        .dn_data  (st_out[g]),
        .dn_ready (st_ready[g+1])
      );
    end
  end

  assign in_ready   = st_ready[0];
  assign out_valid  = st_valid[NST-1];
  assign activation = st_out[NST-1].res;
  assign mode_error = st_out[NST-1].err;

endmodule

`default_nettype wire

// ----- rtl/sau_checker.sv -----
// Port-level checks for the selectable activation unit, bound to the top.
// Depends on sau_pkg and selectable_activation_unit.
`default_nettype none

module sau_checker #(
  parameter int DATA_WIDTH = sau_pkg::DATA_WIDTH_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [DATA_WIDTH-1:0] activation,
  input wire logic                         mode_error
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // a flagged item carries a zero activation
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode_error) |-> (activation == '0))
    else $error("mode_error with nonzero activation");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(activation) && $stable(mode_error)))
    else $error("output item changed while stalled");

  // with the output free, the entry slot is never blocked
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked with output ready");

endmodule

bind selectable_activation_unit sau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sau_checker (.*);

`default_nettype wire

// ----- tb/selectable_activation_unit_tb.sv -----
// Testbench for selectable_activation_unit: directed and random items with
// a scoreboard that predicts each activation. Depends on sau_pkg and the RTL.
`default_nettype none

module selectable_activation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = sau_pkg::DATA_WIDTH_DEF;
  localparam int FB = sau_pkg::FRAC_BITS_DEF;
  // leave margin after the pipe empties, before register writes
  localparam int SETTLE_CYCLES = 70;

  localparam longint ONE_Q30   = longint'(sau_pkg::Q30_ONE);
  localparam longint PI_Q30    = longint'(sau_pkg::Q30_PI);
  localparam longint HPI_Q30   = longint'(sau_pkg::Q30_HALF_PI);
  localparam longint TWOPI_Q30 = longint'(sau_pkg::Q30_TWO_PI);
  localparam longint LN2_Q30   = longint'(sau_pkg::Q30_LN2);
  localparam longint GINV_Q30  = longint'(sau_pkg::Q30_GAIN_INV);

  typedef struct {
    logic signed [DW-1:0] act;
    logic                 err;
  } act_result_t;

  // Predicts activations and holds the results still owed by the block.
  class act_scoreboard;
    act_result_t owed[$];
    logic [15:0] slope;
    int          mismatches;

    function new();
      slope      = sau_pkg::LEAK_SLOPE_RESET;
      mismatches = 0;
    endfunction

    function longint round_q(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // exp(-t), t >= 0, both Q30
    function longint exp_neg(longint t);
      longint k, r, sum, term;
      k = t / LN2_Q30;
      if (k >= 40) return 0;
      r = t - k * LN2_Q30;
      sum = ONE_Q30;
      term = ONE_Q30;
      for (int n = 1; n <= sau_pkg::EXP_TERMS; n++) begin
        term = ((term * r) >> 30) / n;
        if (n % 2) sum -= term;
        else sum += term;
      end
      return sum >> k;
    endfunction

    function longint arctan(longint x);
      longint cx, cy, z, dx, dy;
      cx = longint'(1) << (FB + 28);
      cy = x * (longint'(1) << 28);
      z = 0;
      for (int i = 0; i < sau_pkg::CORDIC_STEPS; i++) begin
        dx = cx >>> i;
        dy = cy >>> i;
        if (cy >= 0) begin
          cx += dy; cy -= dx; z += longint'(sau_pkg::ATAN_TBL[i]);
        end else begin
          cx -= dy; cy += dx; z -= longint'(sau_pkg::ATAN_TBL[i]);
        end
      end
      return z;
    endfunction

    function longint sine(longint a);
      longint cx, cy, z, dx, dy;
      cx = GINV_Q30;
      cy = 0;
      z = a;
      for (int i = 0; i < sau_pkg::CORDIC_STEPS; i++) begin
        dx = cx >>> i;
        dy = cy >>> i;
        if (z >= 0) begin
          cx -= dy; cy += dx; z -= longint'(sau_pkg::ATAN_TBL[i]);
        end else begin
          cx += dy; cy -= dx; z += longint'(sau_pkg::ATAN_TBL[i]);
        end
      end
      return cy;
    endfunction

    function act_result_t activate(logic signed [DW-1:0] v, sau_pkg::mode_t m,
                                   logic outl);
      act_result_t r;
      longint x, mag, e, res, ang;
      x = v;
      mag = (x < 0 ? -x : x) << (30 - FB);
      res = 0;
      r.err = 1'b0;
      if (outl && (m == sau_pkg::MODE_LEAKY || m == sau_pkg::MODE_RELU)) begin
        r.err = 1'b1;
        r.act = '0;
        return r;
      end
      case (m)
        sau_pkg::MODE_ATAN: res = round_q(arctan(x), 30 - FB);
        sau_pkg::MODE_STEP: res = x < 0 ? 0 : (longint'(1) << FB);
        sau_pkg::MODE_ELU: begin
          if (x > 0) res = x;
          else res = round_q((exp_neg(mag) - ONE_Q30) * longint'(slope), 46 - FB);
        end
        sau_pkg::MODE_SIGMOID: begin
          e = exp_neg(mag);
          if (x >= 0) res = (longint'(1) << 60) / (ONE_Q30 + e);
          else res = (e << 30) / (ONE_Q30 + e);
          res = round_q(res, 30 - FB);
        end
        sau_pkg::MODE_SINE: begin
          ang = (x << (30 - FB)) % TWOPI_Q30;   // truncating remainder
          if (ang > PI_Q30) ang -= TWOPI_Q30;
          else if (ang <= -PI_Q30) ang += TWOPI_Q30;
          if (ang > HPI_Q30) ang = PI_Q30 - ang;
          else if (ang < -HPI_Q30) ang = -PI_Q30 - ang;
          res = round_q(sine(ang), 30 - FB);
        end
        sau_pkg::MODE_TANH: begin
          e = exp_neg(mag * 2);
          res = ((ONE_Q30 - e) << 30) / (ONE_Q30 + e);
          if (x < 0) res = -res;
          res = round_q(res, 30 - FB);
        end
        sau_pkg::MODE_LEAKY: res = x < 0 ? round_q(x * longint'(slope), 16) : x;
        default: res = x > 0 ? x : 0;
      endcase
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      r.act = res[DW-1:0];
      return r;
    endfunction

    function void note_item(logic signed [DW-1:0] v, logic [2:0] m, logic outl);
      owed.push_back(activate(v, sau_pkg::mode_t'(m), outl));
    endfunction

    function void check_result(logic signed [DW-1:0] act, logic err);
      act_result_t exp_r;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: act=%0d err=%0b", act, err);
        return;
      end
      exp_r = owed.pop_front();
      if (exp_r.act !== act || exp_r.err !== err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected act=%0d err=%0b, got act=%0d err=%0b",
                   exp_r.act, exp_r.err, act, err);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] value = '0;
  logic [2:0]           mode = sau_pkg::MODE_ATAN;
  logic                 output_layer = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] activation;
  logic                 mode_error;
  logic                 cfg_we = 1'b0;
  logic [15:0]          cfg_wdata = '0;

  act_scoreboard sb = new();
  bit            calm = 1'b0;   // no idling on either side
  int            stall_left = 0;

  selectable_activation_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .value(value), .mode(mode), .output_layer(output_layer),
    .out_valid(out_valid), .out_ready(out_ready),
    .activation(activation), .mode_error(mode_error),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watch both handshakes at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_item(value, mode, output_layer);
      if (out_valid && out_ready) sb.check_result(activation, mode_error);
    end
  end

  // Receiver stalls in random bursts unless calm is set.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0 && !calm) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one item; valid stays up until the block takes it.
  task automatic send_item(logic signed [DW-1:0] v, logic [2:0] m, logic outl);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    value = v;
    mode = m;
    output_layer = outl;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and let the pipe empty before touching the register.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_slope(logic [15:0] s);
    cfg_we = 1'b1;
    cfg_wdata = s;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.slope = s;
  endtask

  task automatic random_items(int n);
    logic signed [DW-1:0] v;
    for (int i = 0; i < n; i++) begin
      // mostly the interesting range near zero, sometimes the whole field
      if ($urandom_range(0, 2) == 0) v = DW'($urandom);
      else v = DW'($urandom_range(0, 32768) - 16384);
      send_item(v, 3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    logic signed [DW-1:0] edges [3];
    edges = '{16'sh8000, 16'sh7fff, 16'sh0000};
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes and zero for every function, then the illegal
    // output-layer selects.
    for (int m = 0; m < 8; m++)
      foreach (edges[j]) send_item(edges[j], 3'(m), 1'b0);
    send_item(-16'sd1, sau_pkg::MODE_LEAKY, 1'b1);
    send_item(16'sd1, sau_pkg::MODE_RELU, 1'b1);
    random_items(120);

    drain();
    write_slope(16'd0);
    random_items(100);
    drain();
    write_slope(16'hffff);
    random_items(100);
    drain();
    write_slope(16'($urandom));
    random_items(100);

    // tail with no idling on either side
    calm = 1'b1;
    random_items(60);
    drain();

    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
